@@ src/wsd_pkg.sv @@
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned OpcW    = 4;
  localparam int unsigned LenW    = 24;
  localparam int unsigned ExtCntW = 4;

  localparam logic [LenW-1:0] MaxMsgReset = LenW'(1 << 20);

  // Opcodes
  localparam logic [OpcW-1:0] OpCont  = 4'h0;
  localparam logic [OpcW-1:0] OpText  = 4'h1;
  localparam logic [OpcW-1:0] OpBin   = 4'h2;
  localparam logic [OpcW-1:0] OpClose = 4'h8;
  localparam logic [OpcW-1:0] OpPing  = 4'h9;
  localparam logic [OpcW-1:0] OpPong  = 4'hA;

  // Short length codes that announce an extended length
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [ExtCntW-1:0] Ext16Bytes = 4'd2;
  localparam logic [ExtCntW-1:0] Ext64Bytes = 4'd8;

  // Result kinds
  localparam logic [KindW-1:0] KindData      = 3'd0;
  localparam logic [KindW-1:0] KindEmptyEnd  = 3'd1;
  localparam logic [KindW-1:0] KindPing      = 3'd2;
  localparam logic [KindW-1:0] KindEmptyPing = 3'd3;
  localparam logic [KindW-1:0] KindClose     = 3'd4;
  localparam logic [KindW-1:0] KindError     = 3'd5;

  // Error codes
  localparam logic [ErrW-1:0] ErrMasked    = 3'd0;
  localparam logic [ErrW-1:0] ErrFrameBig  = 3'd1;
  localparam logic [ErrW-1:0] ErrOverlap   = 3'd2;
  localparam logic [ErrW-1:0] ErrOrphan    = 3'd3;
  localparam logic [ErrW-1:0] ErrMsgBig    = 3'd4;
  localparam logic [ErrW-1:0] ErrBadOpcode = 3'd5;

  typedef enum logic [3:0] {
    PhHdr0 = 4'b0001,
    PhHdr1 = 4'b0010,
    PhExt  = 4'b0100,
    PhPay  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data_byte;
    logic             end_flag;
    logic [ErrW-1:0]  error_code;
  } res_t;

endpackage

@@ src/wsd_if.sv @@
interface wsd_in_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::KindW-1:0] kind;
  logic [wsd_pkg::ByteW-1:0] data_byte;
  logic                      end_flag;
  logic [wsd_pkg::ErrW-1:0]  error_code;

  modport source (output valid, output kind, output data_byte, output end_flag,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input data_byte, input end_flag,
                  input error_code, output ready);
endinterface

@@ src/websocket_frame_deframer_core.sv @@
// WebSocket receive-side deframer: takes one server byte per rx_i transaction, walks the
// two header bytes and the optional 16- or 64-bit extended length, then forwards payload
// bytes on tx_o with at most one result per input byte. Text, binary and continuation
// payload comes out as data bytes (end_flag on the last byte of a final frame), ping
// payload as ping bytes so a pong can be built, and pong frames are dropped. Close and
// protocol errors (masked frame, frame or message above max_message_bytes, overlapping
// message, orphan continuation, unknown opcode) are reported as soon as the header is
// complete; the block then drops every byte until reset. Throughput is one byte per clock:
// each byte is parsed by a single state update, and the result lands in an output register
// backed by one skid entry, so rx_i stays ready until a second result waits on tx_o.
// Write cfg_we_i / cfg_wdata_i only while the block is idle.
module websocket_frame_deframer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wsd_pkg::LenW-1:0]  cfg_wdata_i,
  wsd_in_if.sink                    rx_i,
  wsd_out_if.source                 tx_o
);
  import wsd_pkg::*;

  // Parser state
  phase_e              phase_q, phase_d;
  logic                final_q, final_d;
  logic [OpcW-1:0]     opc_q, opc_d;
  logic                masked_q, masked_d;
  logic [ExtCntW-1:0]  ext_left_q, ext_left_d;
  logic [LenW-1:0]     len_q, len_d;      // low bits of the frame length
  logic                ovf_q, ovf_d;      // frame length has bits above LenW
  logic [LenW-1:0]     pay_left_q, pay_left_d;
  logic                asm_q, asm_d;
  logic [LenW-1:0]     msg_len_q, msg_len_d;
  logic                closed_q, closed_d;
  logic [LenW-1:0]     max_msg_q;

  // Output register plus one skid entry
  logic                out_vld_q, skid_vld_q;
  res_t                out_q, skid_q;

  logic                rx_fire;
  logic                hdr_done;
  logic                res_vld;
  res_t                res;
  logic                last_byte;
  logic [LenW:0]       msg_sum;
  logic                out_free;

  assign rx_i.ready = !skid_vld_q;
  assign rx_fire    = rx_i.valid && !skid_vld_q;
  assign msg_sum    = {1'b0, msg_len_q} + {1'b0, len_d};
  assign last_byte  = (pay_left_q == LenW'(1));

  always_comb begin
    phase_d    = phase_q;
    final_d    = final_q;
    opc_d      = opc_q;
    masked_d   = masked_q;
    ext_left_d = ext_left_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    pay_left_d = pay_left_q;
    asm_d      = asm_q;
    msg_len_d  = msg_len_q;
    closed_d   = closed_q;
    hdr_done   = 1'b0;
    res_vld    = 1'b0;
    res        = '0;

    if (rx_fire && !closed_q) begin
      case (phase_q)
        PhHdr0: begin
          final_d = rx_i.rx_byte[7];
          opc_d   = rx_i.rx_byte[OpcW-1:0];
          phase_d = PhHdr1;
        end
        PhHdr1: begin
          masked_d = rx_i.rx_byte[7];
          ovf_d    = 1'b0;
          if (rx_i.rx_byte[6:0] == Len7Ext16 || rx_i.rx_byte[6:0] == Len7Ext64) begin
            ext_left_d = (rx_i.rx_byte[6:0] == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
            len_d      = '0;
            phase_d    = PhExt;
          end else begin
            len_d    = LenW'(rx_i.rx_byte[6:0]);
            hdr_done = 1'b1;
          end
        end
        PhExt: begin
          // Shift in big-endian; anything pushed past LenW bits sticks in ovf
          ovf_d      = ovf_q || (len_q[LenW-1 -: ByteW] != '0);
          len_d      = {len_q[LenW-ByteW-1:0], rx_i.rx_byte};
          ext_left_d = ext_left_q - ExtCntW'(1);
          if (ext_left_q == ExtCntW'(1)) begin
            hdr_done = 1'b1;
          end
        end
        PhPay: begin
          pay_left_d = pay_left_q - LenW'(1);
          if (last_byte) begin
            phase_d = PhHdr0;
          end
          if (opc_q == OpPing) begin
            res_vld        = 1'b1;
            res.kind       = KindPing;
            res.data_byte  = rx_i.rx_byte;
            res.end_flag   = last_byte;
          end else if (opc_q != OpPong) begin
            res_vld       = 1'b1;
            res.kind      = KindData;
            res.data_byte = rx_i.rx_byte;
            if (last_byte && final_q) begin
              res.end_flag = 1'b1;
              asm_d        = 1'b0;
              msg_len_d    = '0;
            end
          end
        end
        default: begin
          phase_d = PhHdr0;
        end
      endcase

      // Header complete: validate, then report or start the payload
      if (hdr_done) begin
        phase_d = PhHdr0;
        if (masked_d) begin
          res_vld        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrMasked;
          closed_d       = 1'b1;
        end else if (ovf_d || (len_d > max_msg_q)) begin
          res_vld        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrFrameBig;
          closed_d       = 1'b1;
        end else if (opc_d == OpClose) begin
          res_vld  = 1'b1;
          res.kind = KindClose;
          closed_d = 1'b1;
        end else if (opc_d == OpPing) begin
          if (len_d == '0) begin
            res_vld  = 1'b1;
            res.kind = KindEmptyPing;
          end else begin
            pay_left_d = len_d;
            phase_d    = PhPay;
          end
        end else if (opc_d == OpPong) begin
          if (len_d != '0) begin
            pay_left_d = len_d;
            phase_d    = PhPay;
          end
        end else if ((opc_d == OpText || opc_d == OpBin) && asm_q) begin
          res_vld        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrOverlap;
          closed_d       = 1'b1;
        end else if (opc_d == OpCont && !asm_q) begin
          res_vld        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrOrphan;
          closed_d       = 1'b1;
        end else if (opc_d == OpCont && (msg_sum > {1'b0, max_msg_q})) begin
          res_vld        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrMsgBig;
          closed_d       = 1'b1;
        end else if (opc_d != OpText && opc_d != OpBin && opc_d != OpCont) begin
          res_vld        = 1'b1;
          res.kind       = KindError;
          res.error_code = ErrBadOpcode;
          closed_d       = 1'b1;
        end else begin
          // Data frame accepted: open or extend the message
          asm_d     = 1'b1;
          msg_len_d = (opc_d == OpCont) ? msg_sum[LenW-1:0] : len_d;
          if (len_d == '0) begin
            if (final_d) begin
              asm_d     = 1'b0;
              msg_len_d = '0;
              res_vld   = 1'b1;
              res.kind  = KindEmptyEnd;
            end
          end else begin
            pay_left_d = len_d;
            phase_d    = PhPay;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      final_q    <= 1'b0;
      opc_q      <= '0;
      masked_q   <= 1'b0;
      ext_left_q <= '0;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      pay_left_q <= '0;
      asm_q      <= 1'b0;
      msg_len_q  <= '0;
      closed_q   <= 1'b0;
      max_msg_q  <= MaxMsgReset;
    end else begin
      phase_q    <= phase_d;
      final_q    <= final_d;
      opc_q      <= opc_d;
      masked_q   <= masked_d;
      ext_left_q <= ext_left_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      pay_left_q <= pay_left_d;
      asm_q      <= asm_d;
      msg_len_q  <= msg_len_d;
      closed_q   <= closed_d;
      if (cfg_we_i) begin
        max_msg_q <= cfg_wdata_i;
      end
    end
  end

  // A new result goes to the output register when it is empty or draining this
  // cycle; otherwise park it in the skid entry and hold rx_i off.
  assign out_free = !out_vld_q || tx_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (res_vld) begin
      if (out_free) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_vld_q && tx_o.ready) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_vld_q && tx_o.ready && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign tx_o.valid      = out_vld_q;
  assign tx_o.kind       = out_q.kind;
  assign tx_o.data_byte  = out_q.data_byte;
  assign tx_o.end_flag   = out_q.end_flag;
  assign tx_o.error_code = out_q.error_code;

endmodule

@@ bench/wsd_frame_checker.sv @@
`timescale 1ns / 100ps

module wsd_frame_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [wsd_pkg::LenW-1:0] cfg_wdata_i,
  wsd_in_if                        rx_mon,
  wsd_out_if                       tx_mon,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);
  import wsd_pkg::*;

  // Parser state mirrored, with length fields wider than the block's LenW
  logic [LenW-1:0]    limit_q;
  phase_e             ph_q;
  logic               fin_q;
  logic [OpcW-1:0]    opc_q;
  logic [ExtCntW-1:0] ext_left_q;
  logic [63:0]        flen_q;
  logic [24:0]        pay_left_q;
  logic               asm_q;
  logic [24:0]        msg_len_q;
  logic               closed_q;
  logic               masked_q;

  res_t awaited_q[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    fail_count_o++;
  endtask

  function automatic logic raise_error(input logic [ErrW-1:0] code, output res_t r);
    closed_q = 1'b1;
    ph_q     = PhHdr0;
    r        = '0;
    r.kind       = KindError;
    r.error_code = code;
    return 1'b1;
  endfunction

  // Header complete: validate, then arm the payload or emit the header's own result
  function automatic logic finish_header(output res_t r);
    logic [24:0] len;
    r    = '0;
    ph_q = PhHdr0;
    len  = flen_q[24:0];
    if (masked_q) return raise_error(ErrMasked, r);
    if (flen_q > {40'b0, limit_q}) return raise_error(ErrFrameBig, r);
    if (opc_q == OpClose) begin
      closed_q = 1'b1;
      r.kind   = KindClose;
      return 1'b1;
    end
    if (opc_q == OpPing) begin
      if (len == '0) begin
        r.kind = KindEmptyPing;
        return 1'b1;
      end
      pay_left_q = len;
      ph_q       = PhPay;
      return 1'b0;
    end
    if (opc_q == OpPong) begin
      if (len != '0) begin
        pay_left_q = len;
        ph_q       = PhPay;
      end
      return 1'b0;
    end
    if (opc_q == OpText || opc_q == OpBin) begin
      if (asm_q) return raise_error(ErrOverlap, r);
      asm_q     = 1'b1;
      msg_len_q = len;
    end else if (opc_q == OpCont) begin
      if (!asm_q) return raise_error(ErrOrphan, r);
      if (({1'b0, msg_len_q} + {1'b0, len}) > {2'b0, limit_q})
        return raise_error(ErrMsgBig, r);
      msg_len_q = msg_len_q + len;
    end else begin
      return raise_error(ErrBadOpcode, r);
    end
    if (len == '0) begin
      if (fin_q) begin
        asm_q     = 1'b0;
        msg_len_q = '0;
        r.kind    = KindEmptyEnd;
        return 1'b1;
      end
      return 1'b0;
    end
    pay_left_q = len;
    ph_q       = PhPay;
    return 1'b0;
  endfunction

  // Advance the parser by one received byte; return 1 when a result is due
  function automatic logic parse_byte(input logic [ByteW-1:0] b, output res_t r);
    logic last;
    r = '0;
    if (closed_q) return 1'b0;
    case (ph_q)
      PhHdr0: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ph_q  = PhHdr1;
        return 1'b0;
      end
      PhHdr1: begin
        masked_q = b[7];
        flen_q   = {57'b0, b[6:0]};
        if (b[6:0] == Len7Ext16 || b[6:0] == Len7Ext64) begin
          ext_left_q = (b[6:0] == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
          flen_q     = '0;
          ph_q       = PhExt;
          return 1'b0;
        end
        return finish_header(r);
      end
      PhExt: begin
        flen_q     = {flen_q[55:0], b};
        ext_left_q = ext_left_q - ExtCntW'(1);
        if (ext_left_q != '0) return 1'b0;
        return finish_header(r);
      end
      default: begin
        pay_left_q = pay_left_q - 25'd1;
        last       = (pay_left_q == '0);
        if (last) ph_q = PhHdr0;
        if (opc_q == OpPing) begin
          r.kind      = KindPing;
          r.data_byte = b;
          r.end_flag  = last;
          return 1'b1;
        end
        if (opc_q == OpPong) return 1'b0;
        r.kind      = KindData;
        r.data_byte = b;
        if (last && fin_q) begin
          asm_q      = 1'b0;
          msg_len_q  = '0;
          r.end_flag = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t predicted;
    res_t got;
    res_t want;
    if (!rst_ni) begin
      limit_q      = MaxMsgReset;
      ph_q         = PhHdr0;
      fin_q        = 1'b0;
      opc_q        = '0;
      ext_left_q   = '0;
      flen_q       = '0;
      pay_left_q   = '0;
      asm_q        = 1'b0;
      msg_len_q    = '0;
      closed_q     = 1'b0;
      masked_q     = 1'b0;
      awaited_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (rx_mon.valid && rx_mon.ready) begin
        if (parse_byte(rx_mon.rx_byte, predicted)) awaited_q.push_back(predicted);
      end
      if (tx_mon.valid && tx_mon.ready) begin
        got = '{kind: tx_mon.kind, data_byte: tx_mon.data_byte,
                end_flag: tx_mon.end_flag, error_code: tx_mon.error_code};
        checked_o++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h end %0b code %0d",
                                    got.kind, got.data_byte, got.end_flag, got.error_code));
        end else begin
          want = awaited_q.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got kind %0d byte %02h end %0b code %0d, want kind %0d byte %02h end %0b code %0d",
              got.kind, got.data_byte, got.end_flag, got.error_code,
              want.kind, want.data_byte, want.end_flag, want.error_code));
        end
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

@@ bench/tb_websocket_frame_deframer_core.sv @@
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_core;
  import wsd_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int SettleCycles = 16;

  // Length encodings of a frame header
  localparam int FormShort = 0;
  localparam int FormExt16 = 1;
  localparam int FormExt64 = 2;

  // Byte counts at which each limit setting hands over to the next
  localparam int unsigned DefaultEnd = 600;
  localparam int unsigned ZeroEnd    = 850;
  localparam int unsigned WideEnd    = 1350;
  localparam int unsigned MidEnd     = 1750;
  localparam int unsigned TightEnd   = 1850;

  // How the stream is finally torn down; only one per run since the block
  // stays closed until reset
  typedef enum int {
    EndClose, EndMasked, EndFrameBig, EndOverlap,
    EndOrphan, EndMsgBig, EndBadOpcode, EndStacked
  } stream_end_e;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;

  wsd_in_if  rx_bus ();
  wsd_out_if tx_bus ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Stimulus-side view of the stream: frame legality, idle rates, limits and teardown
  int unsigned bytes_sent;
  int unsigned cur_max;
  logic        in_message;
  int unsigned msg_bytes;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mid_limit;
  int unsigned tight_limit;
  stream_end_e how_ended;

  websocket_frame_deframer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_bus),
    .tx_o        (tx_bus)
  );

  wsd_frame_checker frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .rx_mon       (rx_bus),
    .tx_mon       (tx_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Result side: stall at random, per cycle, at the current idle rate
  always @(negedge clk) begin
    tx_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Drive one byte as a transaction: optional idle cycles first, then hold
  // valid until the block takes it. Enter and leave at a falling edge.
  task automatic push_byte(input logic [ByteW-1:0] b);
    // Idle profile by thirds: sender light / receiver heavy, swapped, then none
    if (bytes_sent < TightEnd / 3) begin
      src_idle_pct = 15;
      snk_idle_pct = 67;
    end else if (bytes_sent < 2 * TightEnd / 3) begin
      src_idle_pct = 67;
      snk_idle_pct = 15;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_bus.valid <= 1'b0;
      @(negedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Reserved header bits are random: the block must ignore them
  task automatic send_header(input logic fin, input logic [OpcW-1:0] opc,
                             input logic masked, input logic [63:0] len, input int form);
    logic [2:0] rsv;
    int         k;
    rsv = 3'($urandom_range(0, 7));
    push_byte({fin, rsv, opc});
    case (form)
      FormShort: push_byte({masked, len[6:0]});
      FormExt16: begin
        push_byte({masked, Len7Ext16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, Len7Ext64});
        for (k = 7; k >= 0; k--) push_byte(len[k*8 +: 8]);
      end
    endcase
  endtask

  // Short code where it fits, but often spell small lengths out long-hand
  function automatic int pick_form(input logic [63:0] len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (len > 64'd65535) return FormExt64;
    if (len > 64'd125) return (r < 80) ? FormExt16 : FormExt64;
    if (r < 70) return FormShort;
    return (r < 90) ? FormExt16 : FormExt64;
  endfunction

  // Mostly short frames, some empty, a few past the 7-bit code; clip to room
  function automatic int unsigned pick_len(input int unsigned room);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 10)      len = 0;
    else if (r < 80) len = $urandom_range(1, 12);
    else if (r < 95) len = $urandom_range(13, 40);
    else             len = $urandom_range(126, 300);
    return (len > room) ? room : len;
  endfunction

  function automatic logic [OpcW-1:0] pick_bad_opcode();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r < 5) ? OpcW'(3 + r) : OpcW'(11 + r - 5);
  endfunction

  // One well-formed frame: control frames interleave freely with fragments
  task automatic random_frame();
    int unsigned     pick;
    int unsigned     len;
    logic            fin;
    logic [OpcW-1:0] opc;
    pick = $urandom_range(0, 99);
    fin  = ($urandom_range(0, 2) != 0);
    if (pick < 25) begin
      opc = (pick < 15) ? OpPing : OpPong;
      len = pick_len(cur_max);
    end else begin
      len = pick_len(cur_max - msg_bytes);
      if (in_message) opc = OpCont;
      else opc = ($urandom_range(0, 1) != 0) ? OpText : OpBin;
      in_message = !fin;
      msg_bytes  = fin ? 0 : msg_bytes + len;
    end
    send_header(fin, opc, 1'b0, 64'(len), pick_form(64'(len)));
    send_payload(len);
  endtask

  task automatic random_frames_until(input int unsigned byte_mark);
    while (bytes_sent < byte_mark) random_frame();
  endtask

  // Close any open fragmented message with an empty final continuation
  task automatic end_message();
    if (in_message) send_header(1'b1, OpCont, 1'b0, 64'd0, pick_form(64'd0));
    in_message = 1'b0;
    msg_bytes  = 0;
  endtask

  // Drop valid and wait out every expected result plus the block's own latency
  task automatic drain();
    rx_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limit(input int unsigned value);
    end_message();
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= LenW'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_max   = value;
  endtask

  // Tear the stream down once: close or one of the protocol errors
  task automatic end_stream();
    logic [63:0] big;
    how_ended = stream_end_e'($urandom_range(0, 7));
    case (how_ended)
      EndClose: begin
        send_header(1'($urandom_range(0, 1)), OpClose, 1'b0, 64'd1, FormShort);
      end
      EndMasked: begin
        send_header(1'b1, OpText, 1'b1, 64'd1, pick_form(64'd1));
      end
      EndFrameBig: begin
        if ($urandom_range(0, 1) != 0) begin
          // Upper bytes of the 64-bit length must count too
          big = {$urandom(), $urandom()};
          big[56 + $urandom_range(0, 7)] = 1'b1;
          send_header(1'b1, OpBin, 1'b0, big, FormExt64);
        end else begin
          big = 64'(cur_max + $urandom_range(1, 200));
          send_header(1'b1, OpPing, 1'b0, big, pick_form(big));
        end
      end
      EndOverlap: begin
        if (!in_message) begin
          send_header(1'b0, OpText, 1'b0, 64'd1, FormShort);
          send_payload(1);
        end
        send_header(1'b1, OpBin, 1'b0, 64'd0, FormShort);
      end
      EndOrphan: begin
        end_message();
        send_header(1'b1, OpCont, 1'b0, 64'd0, FormShort);
      end
      EndMsgBig: begin
        end_message();
        send_header(1'b0, OpText, 1'b0, 64'(cur_max), pick_form(64'(cur_max)));
        send_payload(cur_max);
        send_header(1'b1, OpCont, 1'b0, 64'd1, FormShort);
      end
      EndBadOpcode: begin
        send_header(1'($urandom_range(0, 1)), pick_bad_opcode(), 1'b0, 64'd1, FormShort);
      end
      default: begin
        // Masked, oversize and unknown opcode together: masked wins
        send_header(1'b1, pick_bad_opcode(), 1'b1, 64'(cur_max + 5), FormExt16);
      end
    endcase
    // Everything after this is dropped by the closed block
    send_payload(12);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    tx_bus.ready   = 1'b0;
    bytes_sent     = 0;
    cur_max        = 32'(MaxMsgReset);
    in_message     = 1'b0;
    msg_bytes      = 0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    how_ended      = EndClose;
    mid_limit      = $urandom_range(1, 60);
    tight_limit    = $urandom_range(1, 8);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes, every opcode but close, empty ping/pong/message,
    // a 16-bit extended length and a fragment split by a ping
    send_header(1'b1, OpText, 1'b0, 64'd2, FormShort);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_header(1'b1, OpPing, 1'b0, 64'd0, FormShort);
    send_header(1'b1, OpPing, 1'b0, 64'd1, FormExt16);
    push_byte(8'h5A);
    send_header(1'b1, OpPong, 1'b0, 64'd0, FormShort);
    send_header(1'b1, OpBin, 1'b0, 64'd0, FormShort);
    send_header(1'b0, OpBin, 1'b0, 64'd1, FormShort);
    push_byte(8'h33);
    send_header(1'b0, OpPing, 1'b0, 64'd0, FormShort);
    send_header(1'b1, OpCont, 1'b0, 64'd1, FormShort);
    push_byte(8'hC4);

    // Random frames under reset limit, then zero, full range, mid and tight
    random_frames_until(DefaultEnd);
    set_limit(0);
    random_frames_until(ZeroEnd);
    set_limit(24'hFF_FFFF);
    random_frames_until(WideEnd);
    set_limit(mid_limit);
    random_frames_until(MidEnd);
    set_limit(tight_limit);
    random_frames_until(TightEnd);
    end_stream();
    drain();

    $display("Sent %0d bytes under limits 1M, 0, 24'hFFFFFF, %0d and %0d; %0d results compared.",
             bytes_sent, mid_limit, tight_limit, checked);
    $display("Stream torn down by %s.", how_ended.name());
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(ClkPeriod * 400000);
    $display("Timeout with %0d results still pending", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
